// File: sv/tdp_pkg.sv
package tdp_pkg;

  localparam int unsigned GridN    = 5;
  localparam int unsigned WordW    = 25;
  localparam int unsigned DataW    = 16;
  localparam int unsigned CheckW   = 9;
  localparam int unsigned StatusW  = 2;

  // operation codes
  typedef enum logic {
    FUNC_ENCODE  = 1'b0,
    FUNC_CORRECT = 1'b1
  } func_t;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_UNCORR    = 2'd2
  } status_t;

  // codeword bit position of grid cell [row][col]
  localparam logic [4:0] POS_MAP [GridN][GridN] = '{
    '{5'h0f, 5'h0e, 5'h0d, 5'h0c, 5'h13},
    '{5'h0b, 5'h0a, 5'h09, 5'h08, 5'h12},
    '{5'h07, 5'h06, 5'h05, 5'h04, 5'h11},
    '{5'h03, 5'h02, 5'h01, 5'h00, 5'h10},
    '{5'h14, 5'h15, 5'h16, 5'h17, 5'h18}
  };

  // bits of one row group or one column group
  function automatic logic [WordW-1:0] group_mask(input logic is_col, input int unsigned k);
    logic [WordW-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < GridN; i++) begin
      if (is_col) begin
        m[POS_MAP[i][k]] = 1'b1;
      end else begin
        m[POS_MAP[k][i]] = 1'b1;
      end
    end
    return m;
  endfunction

  // exactly one bit set in a group flag vector
  function automatic logic one_hot(input logic [GridN-1:0] v);
    logic [2:0] cnt;
    cnt = '0;
    for (int unsigned i = 0; i < GridN; i++) begin
      cnt = cnt + {2'b00, v[i]};
    end
    return cnt == 3'd1;
  endfunction

endpackage

// File: sv/two_d_parity_4x4_codec_core.sv
// two-dimensional odd-parity codec over a 4x4 data grid (25-bit codeword,
// 9 check bits in positions 24..16). raise start with in_func/in_word_in to
// transfer one item; busy is always low, so a new item can be taken every
// cycle. each item produces exactly one result after the three register
// stages (input capture, group parity, classify/correct): out_valid pulses
// for one cycle with out_word_out and out_status, and the receiver cannot
// stall, so capture it in that cycle. throughput is one item per clock.
// encode (in_func = 0) uses in_word_in[15:0] and returns the check bits in
// out_word_out[8:0]; correct (in_func = 1) returns the word unchanged
// (status 0), with one bit flipped (status 1), or zero when uncorrectable
// (status 2).
module two_d_parity_4x4_codec_core
  import tdp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic [WordW-1:0]     in_word_in,
  output logic                 out_valid,
  output logic [WordW-1:0]     out_word_out,
  output logic [StatusW-1:0]   out_status
);

  // pipeline never stalls, so the input side is always open
  assign busy = 1'b0;

  // stage 1: input capture
  logic             s1_valid_r;
  logic             s1_func_r;
  logic [WordW-1:0] s1_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_func_r <= in_func;
    s1_word_r <= in_word_in;
  end

  // stage 2: row and column group parity
  // a group has failed when its bits have even parity; in encode mode the
  // check positions are zeroed, so a failing data row/column is exactly the
  // check bit that must be set
  logic [WordW-1:0] s2_word_nxt;
  logic [GridN-1:0] s2_row_fail_nxt;
  logic [GridN-1:0] s2_col_fail_nxt;

  logic             s2_valid_r;
  logic             s2_func_r;
  logic [WordW-1:0] s2_word_r;
  logic [GridN-1:0] s2_row_fail_r;
  logic [GridN-1:0] s2_col_fail_r;

  always_comb begin
    if (func_t'(s1_func_r) == FUNC_ENCODE) begin
      s2_word_nxt = {{(WordW-DataW){1'b0}}, s1_word_r[DataW-1:0]};
    end else begin
      s2_word_nxt = s1_word_r;
    end
    for (int unsigned k = 0; k < GridN; k++) begin
      s2_row_fail_nxt[k] = ~^(s2_word_nxt & group_mask(1'b0, k));
      s2_col_fail_nxt[k] = ~^(s2_word_nxt & group_mask(1'b1, k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_func_r     <= s1_func_r;
    s2_word_r     <= s2_word_nxt;
    s2_row_fail_r <= s2_row_fail_nxt;
    s2_col_fail_r <= s2_col_fail_nxt;
  end

  // stage 3: classify and correct
  logic [CheckW-1:0] chk;
  logic [WordW-1:0]  flip;
  logic [WordW-1:0]  word_out_nxt;
  status_t           status_nxt;

  always_comb begin
    // check bits in codeword order 16..24: row checks bottom-up, then the
    // column checks, then the check over the row-check column
    chk[0] = s2_row_fail_r[3];
    chk[1] = s2_row_fail_r[2];
    chk[2] = s2_row_fail_r[1];
    chk[3] = s2_row_fail_r[0];
    for (int unsigned c = 0; c < GridN - 1; c++) begin
      chk[4 + c] = s2_col_fail_r[c];
    end
    chk[8] = ~^s2_row_fail_r[3:0];

    // bit where a failing row crosses a failing column
    flip = '0;
    for (int unsigned r = 0; r < GridN; r++) begin
      for (int unsigned c = 0; c < GridN; c++) begin
        if (s2_row_fail_r[r] && s2_col_fail_r[c]) begin
          flip[POS_MAP[r][c]] = 1'b1;
        end
      end
    end

    if (func_t'(s2_func_r) == FUNC_ENCODE) begin
      word_out_nxt = {{(WordW-CheckW){1'b0}}, chk};
      status_nxt   = ST_CLEAN;
    end else if (s2_row_fail_r == '0 && s2_col_fail_r == '0) begin
      word_out_nxt = s2_word_r;
      status_nxt   = ST_CLEAN;
    end else if (one_hot(s2_row_fail_r) && one_hot(s2_col_fail_r)) begin
      word_out_nxt = s2_word_r ^ flip;
      status_nxt   = ST_CORRECTED;
    end else begin
      word_out_nxt = '0;
      status_nxt   = ST_UNCORR;
    end
  end

  logic                out_valid_r;
  logic [WordW-1:0]    out_word_r;
  logic [StatusW-1:0]  out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= word_out_nxt;
    out_status_r <= status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_word_out = out_word_r;
  assign out_status   = out_status_r;

endmodule
